FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers shared by the RTL files. Defining
// NO_ASSERTIONS removes every check.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// A property that must hold at every clock edge outside reset.
`define PFE_ASSERT(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// An antecedent that must be met by a consequent in the same cycle.
`define PFE_ASSERT_IMPL(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

`else

`define PFE_ASSERT(lbl, clk, rst, prop)
`define PFE_ASSERT_IMPL(lbl, clk, rst, ante, cons)

`endif

`endif

FILE: hdl/pfe_pkg.sv
// ----------------------------------------------------------------------------
// Palette fade engine package
// Sizes, colour constants, codes and word types shared by the engine files.
// ----------------------------------------------------------------------------
package pfe_pkg;

  // Palette size and the widths that follow from it.
  localparam int ENTRIES = 64;
  localparam int IDX_W   = 6;
  localparam int ADDR_W  = $clog2(ENTRIES);
  localparam int MAX_W   = (ADDR_W > IDX_W) ? ADDR_W : IDX_W;
  localparam int CMP_W   = MAX_W + 1;
  // Highest entry a fade step may touch: the palette end or the index range.
  localparam int FADE_LIMIT = (ENTRIES < (1 << IDX_W)) ? ENTRIES - 1 : (1 << IDX_W) - 1;

  localparam int COLOR_W = 16;
  localparam int CFG_W   = 6;

  typedef logic [IDX_W-1:0]   idx_t;
  typedef logic [ADDR_W-1:0]  addr_t;
  typedef logic [COLOR_W-1:0] color_t;

  // Channel masks and single steps of a 0BGR colour word.
  localparam color_t CH_R       = 16'h000E;
  localparam color_t CH_G       = 16'h00E0;
  localparam color_t CH_B       = 16'h0E00;
  localparam color_t ST_R       = 16'h0002;
  localparam color_t ST_G       = 16'h0020;
  localparam color_t ST_B       = 16'h0200;
  localparam color_t WHITE_WORD = 16'h0EEE;

  typedef enum logic [1:0] {
    FN_WR_ACT = 2'd0,
    FN_WR_TGT = 2'd1,
    FN_FADE   = 2'd2,
    FN_RD_ACT = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    FM_BLACK      = 2'd0,
    FM_TARGET     = 2'd1,
    FM_FROM_WHITE = 2'd2,
    FM_WHITE      = 2'd3
  } fade_mode_e;

  typedef enum logic [1:0] {
    CFG_MODE  = 2'd0,
    CFG_FIRST = 2'd1,
    CFG_SPAN  = 2'd2
  } cfg_reg_e;

  // Request and response words.
  typedef struct packed {
    func_e  func;
    idx_t   entry_index;
    color_t color_word;
  } req_t;

  typedef struct packed {
    idx_t   out_index;
    color_t out_color;
    logic   last;
  } rsp_t;

  // One cycle's access to a palette memory.
  typedef struct packed {
    logic   wr_en;
    addr_t  wr_addr;
    color_t wr_data;
    logic   rd_en;
    addr_t  rd_addr;
  } ram_cmd_t;

  // Memory address of a palette index.
  function automatic addr_t to_addr(idx_t i);
    logic [MAX_W-1:0] w;
    w = MAX_W'(i);
    return w[ADDR_W-1:0];
  endfunction

  // True when the index names an entry that exists.
  function automatic logic idx_ok(idx_t i);
    return CMP_W'(i) < CMP_W'(ENTRIES);
  endfunction

endpackage

FILE: hdl/pfe_pal_ram.sv
// ----------------------------------------------------------------------------
// Palette memory
// One palette of colour words with a registered read port and a write port.
// Entries never written since reset read as zero.
// ----------------------------------------------------------------------------
module pfe_pal_ram (
  input  logic             clk,
  input  logic             rst,
  input  pfe_pkg::ram_cmd_t cmd,
  output pfe_pkg::color_t  rd_data
);

  pfe_pkg::color_t             mem [pfe_pkg::ENTRIES];
  logic [pfe_pkg::ENTRIES-1:0] filled;
  pfe_pkg::color_t             rd_q;
  logic                        rd_filled;

  // Storage array: write and registered read.
  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[cmd.wr_addr] <= cmd.wr_data;
    end
    if (cmd.rd_en) begin
      rd_q <= mem[cmd.rd_addr];
    end
  end

  // Written flags stand in for clearing the array at reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      filled    <= '0;
      rd_filled <= 1'b0;
    end else begin
      if (cmd.wr_en) begin
        filled[cmd.wr_addr] <= 1'b1;
      end
      if (cmd.rd_en) begin
        rd_filled <= filled[cmd.rd_addr];
      end
    end
  end

  assign rd_data = rd_filled ? rd_q : '0;

endmodule

FILE: hdl/pfe_step.sv
// ----------------------------------------------------------------------------
// Fade step
// Moves one colour word by a single channel step according to the fade mode.
// ----------------------------------------------------------------------------
module pfe_step (
  input  pfe_pkg::fade_mode_e mode,
  input  pfe_pkg::color_t     cur,
  input  pfe_pkg::color_t     tgt,
  output pfe_pkg::color_t     nxt
);

  pfe_pkg::color_t dec_b;
  pfe_pkg::color_t dec_g;

  assign dec_b = cur - pfe_pkg::ST_B;
  assign dec_g = cur - pfe_pkg::ST_G;

  // Channel priority and direction per mode.
  always_comb begin
    nxt = cur;
    case (mode)
      pfe_pkg::FM_BLACK: begin
        if ((cur & pfe_pkg::CH_R) != '0) nxt = cur - pfe_pkg::ST_R;
        else if ((cur & pfe_pkg::CH_G) != '0) nxt = cur - pfe_pkg::ST_G;
        else if ((cur & pfe_pkg::CH_B) != '0) nxt = cur - pfe_pkg::ST_B;
      end
      pfe_pkg::FM_TARGET: begin
        if (cur != tgt) begin
          if ((cur & pfe_pkg::CH_R) != (tgt & pfe_pkg::CH_R)) begin
            nxt = ((cur & pfe_pkg::CH_R) < (tgt & pfe_pkg::CH_R)) ?
                  cur + pfe_pkg::ST_R : cur - pfe_pkg::ST_R;
          end else if ((cur & pfe_pkg::CH_G) != (tgt & pfe_pkg::CH_G)) begin
            nxt = ((cur & pfe_pkg::CH_G) < (tgt & pfe_pkg::CH_G)) ?
                  cur + pfe_pkg::ST_G : cur - pfe_pkg::ST_G;
          end else if ((cur & pfe_pkg::CH_B) != (tgt & pfe_pkg::CH_B)) begin
            nxt = ((cur & pfe_pkg::CH_B) < (tgt & pfe_pkg::CH_B)) ?
                  cur + pfe_pkg::ST_B : cur - pfe_pkg::ST_B;
          end
        end
      end
      pfe_pkg::FM_FROM_WHITE: begin
        // Blue, then green, as long as the word stays at or above the
        // target; otherwise red drops with wrap-around.
        if (cur != tgt) begin
          if (cur >= pfe_pkg::ST_B && dec_b >= tgt) nxt = dec_b;
          else if (cur >= pfe_pkg::ST_G && dec_g >= tgt) nxt = dec_g;
          else nxt = cur - pfe_pkg::ST_R;
        end
      end
      pfe_pkg::FM_WHITE: begin
        if (cur != pfe_pkg::WHITE_WORD) begin
          if ((cur & pfe_pkg::CH_R) != pfe_pkg::CH_R) nxt = cur + pfe_pkg::ST_R;
          else if ((cur & pfe_pkg::CH_G) != pfe_pkg::CH_G) nxt = cur + pfe_pkg::ST_G;
          else if ((cur & pfe_pkg::CH_B) != pfe_pkg::CH_B) nxt = cur + pfe_pkg::ST_B;
        end
      end
      default: nxt = cur;
    endcase
  end

endmodule

FILE: hdl/palette_fade_engine_unit.sv
// ----------------------------------------------------------------------------
// Palette fade engine
// Active and target palettes with entry access and stepwise colour fading.
// ----------------------------------------------------------------------------
// A write, target write or read passes from idle to a response state that
// loads its response word once the output register is free, and the next
// request is taken after the engine has returned to idle.
// A fade step reads the first entry of both palettes on acceptance and then
// handles each entry of the span, up to 64 entries, using the one read port of
// each palette, which reads the next entry while the current one is written
// back. Stalls on the response side hold the fade at the current entry.
// Both palettes read as zero after reset with no clearing pass.
// Configuration writes are always taken.
`include "assert_macros.svh"

module palette_fade_engine_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            req_valid,
  output logic                            req_ready,
  input  pfe_pkg::req_t                   req,
  output logic                            rsp_valid,
  input  logic                            rsp_ready,
  output pfe_pkg::rsp_t                   rsp,
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [1:0]                      cfg_index,
  input  logic [pfe_pkg::CFG_W-1:0]       cfg_data
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_ONE,
    ST_FADE
  } state_t;

  state_t              state;
  pfe_pkg::fade_mode_e fade_mode;
  pfe_pkg::idx_t       fade_first;
  pfe_pkg::idx_t       fade_span;

  pfe_pkg::idx_t       cur_idx;
  pfe_pkg::idx_t       last_idx;
  pfe_pkg::color_t     hold_word;
  logic                use_hold;
  logic                in_rng;

  pfe_pkg::ram_cmd_t   act_cmd;
  pfe_pkg::ram_cmd_t   tgt_cmd;
  pfe_pkg::color_t     act_rd;
  pfe_pkg::color_t     tgt_rd;
  pfe_pkg::color_t     step_nxt;

  logic                out_free;
  logic                rsp_load;
  logic                first_ok;
  logic [pfe_pkg::IDX_W:0] span_end;
  pfe_pkg::idx_t       fade_end;
  pfe_pkg::idx_t       nxt_idx;

  assign req_ready = (state == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !rsp_valid || rsp_ready;
  assign rsp_load  = ((state == ST_ONE) || (state == ST_FADE)) && out_free;
  assign first_ok  = pfe_pkg::idx_ok(fade_first);
  assign nxt_idx   = cur_idx + pfe_pkg::IDX_W'(1);

  // Last entry of a fade: the end of the span, clipped to the palette.
  assign span_end = {1'b0, fade_first} + {1'b0, fade_span};
  assign fade_end = (span_end > (pfe_pkg::IDX_W+1)'(pfe_pkg::FADE_LIMIT)) ?
                    pfe_pkg::IDX_W'(pfe_pkg::FADE_LIMIT) : span_end[pfe_pkg::IDX_W-1:0];

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      fade_mode  <= pfe_pkg::FM_BLACK;
      fade_first <= '0;
      fade_span  <= pfe_pkg::IDX_W'(63);
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        pfe_pkg::CFG_MODE:  fade_mode  <= pfe_pkg::fade_mode_e'(cfg_data[1:0]);
        pfe_pkg::CFG_FIRST: fade_first <= cfg_data[pfe_pkg::IDX_W-1:0];
        pfe_pkg::CFG_SPAN:  fade_span  <= cfg_data[pfe_pkg::IDX_W-1:0];
        default: ;
      endcase
    end
  end

  pfe_pal_ram u_act_ram (
    .clk     (clk),
    .rst     (rst),
    .cmd     (act_cmd),
    .rd_data (act_rd)
  );

  pfe_pal_ram u_tgt_ram (
    .clk     (clk),
    .rst     (rst),
    .cmd     (tgt_cmd),
    .rd_data (tgt_rd)
  );

  pfe_step u_step (
    .mode (fade_mode),
    .cur  (act_rd),
    .tgt  (tgt_rd),
    .nxt  (step_nxt)
  );

  // Memory accesses. A fade writes back the current entry while it reads
  // the next, so the two never touch the same entry in one cycle.
  always_comb begin
    act_cmd = '0;
    tgt_cmd = '0;
    case (state)
      ST_IDLE: begin
        if (req_valid) begin
          case (req.func)
            pfe_pkg::FN_WR_ACT: begin
              act_cmd.wr_en   = pfe_pkg::idx_ok(req.entry_index);
              act_cmd.wr_addr = pfe_pkg::to_addr(req.entry_index);
              act_cmd.wr_data = req.color_word;
            end
            pfe_pkg::FN_WR_TGT: begin
              tgt_cmd.wr_en   = pfe_pkg::idx_ok(req.entry_index);
              tgt_cmd.wr_addr = pfe_pkg::to_addr(req.entry_index);
              tgt_cmd.wr_data = req.color_word;
              act_cmd.rd_en   = 1'b1;
              act_cmd.rd_addr = pfe_pkg::to_addr(req.entry_index);
            end
            pfe_pkg::FN_RD_ACT: begin
              act_cmd.rd_en   = 1'b1;
              act_cmd.rd_addr = pfe_pkg::to_addr(req.entry_index);
            end
            pfe_pkg::FN_FADE: begin
              act_cmd.rd_en   = first_ok;
              act_cmd.rd_addr = pfe_pkg::to_addr(fade_first);
              tgt_cmd.rd_en   = first_ok;
              tgt_cmd.rd_addr = pfe_pkg::to_addr(fade_first);
            end
            default: ;
          endcase
        end
      end
      ST_FADE: begin
        if (out_free) begin
          act_cmd.wr_en   = 1'b1;
          act_cmd.wr_addr = pfe_pkg::to_addr(cur_idx);
          act_cmd.wr_data = step_nxt;
          if (cur_idx != last_idx) begin
            act_cmd.rd_en   = 1'b1;
            act_cmd.rd_addr = pfe_pkg::to_addr(nxt_idx);
            tgt_cmd.rd_en   = 1'b1;
            tgt_cmd.rd_addr = pfe_pkg::to_addr(nxt_idx);
          end
        end
      end
      default: ;
    endcase
  end

  // Sequencer and response register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (req_valid) begin
            cur_idx   <= (req.func == pfe_pkg::FN_FADE) ? fade_first : req.entry_index;
            hold_word <= req.color_word;
            use_hold  <= (req.func == pfe_pkg::FN_WR_ACT);
            in_rng    <= pfe_pkg::idx_ok(req.entry_index);
            case (req.func)
              pfe_pkg::FN_FADE: begin
                if (first_ok) begin
                  last_idx <= fade_end;
                  state    <= ST_FADE;
                end
              end
              default: state <= ST_ONE;
            endcase
          end
        end
        ST_ONE: begin
          if (out_free) begin
            rsp.out_index <= cur_idx;
            rsp.out_color <= !in_rng ? '0 : (use_hold ? hold_word : act_rd);
            rsp.last      <= 1'b1;
            state         <= ST_IDLE;
          end
        end
        ST_FADE: begin
          if (out_free) begin
            rsp.out_index <= cur_idx;
            rsp.out_color <= step_nxt;
            rsp.last      <= (cur_idx == last_idx);
            if (cur_idx == last_idx) begin
              state <= ST_IDLE;
            end else begin
              cur_idx <= nxt_idx;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  // A word of a fade that is not the last means the fade is still running.
  `PFE_ASSERT_IMPL(a_fade_open, clk, rst, rsp_valid && !rsp.last, state == ST_FADE)
  // A fade write-back only happens when its response word can be loaded.
  `PFE_ASSERT_IMPL(a_wb_room, clk, rst, act_cmd.wr_en && state == ST_FADE, out_free)
  // The fade position never passes the final entry.
  `PFE_ASSERT_IMPL(a_fade_bound, clk, rst, state == ST_FADE, cur_idx <= last_idx)

endmodule

FILE: verif/palette_fade_engine_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Palette fade engine unit test
// Self-checking bench for the palette fade engine. A clocked driver feeds
// request words from a backlog, a clocked monitor takes response words, and
// a predictor holding its own copy of both palettes and of the fade registers
// works out the response words due for every accepted request. A directed
// opening covers the field extremes, all functions and the fade corner cases.
// Random phases with fresh fade settings follow. Both sides idle at random,
// and once the response side holds off long enough for the engine to stall.
// ----------------------------------------------------------------------------
module palette_fade_engine_unit_test;

  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 80;
  localparam int RAND_PHASES = 10;
  localparam int PHASE_ITEMS = 30;

  logic                      clk       = 1'b0;
  logic                      rst       = 1'b1;
  logic                      req_valid = 1'b0;
  logic                      req_ready;
  pfe_pkg::req_t             req       = '0;
  logic                      rsp_valid;
  logic                      rsp_ready = 1'b0;
  pfe_pkg::rsp_t             rsp;
  logic                      cfg_valid = 1'b0;
  logic                      cfg_ready;
  logic [1:0]                cfg_index = '0;
  logic [pfe_pkg::CFG_W-1:0] cfg_data  = '0;

  // Predictor state: both palettes and the fade registers.
  pfe_pkg::color_t     act_pal [pfe_pkg::ENTRIES] = '{default: '0};
  pfe_pkg::color_t     tgt_pal [pfe_pkg::ENTRIES] = '{default: '0};
  pfe_pkg::fade_mode_e cur_mode  = pfe_pkg::FM_BLACK;
  pfe_pkg::idx_t       cur_first = '0;
  pfe_pkg::idx_t       cur_span  = pfe_pkg::idx_t'(63);

  pfe_pkg::req_t req_backlog[$];
  pfe_pkg::rsp_t awaited_words[$];
  int   n_queued = 0;
  int   n_taken  = 0;
  int   n_bad    = 0;

  logic          tx_calm   = 1'b0;
  logic          rx_calm   = 1'b0;
  logic          hold_arm  = 1'b0;
  int unsigned   hold_left = 0;
  int unsigned   tx_wait   = 0;
  int unsigned   rx_wait   = 0;
  pfe_pkg::rsp_t want_w;

  palette_fade_engine_unit uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // One fade step of a single colour word in the given mode.
  function automatic pfe_pkg::color_t faded_colour(pfe_pkg::fade_mode_e m,
                                                   pfe_pkg::color_t c,
                                                   pfe_pkg::color_t t);
    pfe_pkg::color_t d;
    case (m)
      pfe_pkg::FM_BLACK: begin
        if ((c & pfe_pkg::CH_R) != 0) return c - pfe_pkg::ST_R;
        if ((c & pfe_pkg::CH_G) != 0) return c - pfe_pkg::ST_G;
        if ((c & pfe_pkg::CH_B) != 0) return c - pfe_pkg::ST_B;
        return c;
      end
      pfe_pkg::FM_TARGET: begin
        if ((c & pfe_pkg::CH_R) < (t & pfe_pkg::CH_R)) return c + pfe_pkg::ST_R;
        if ((c & pfe_pkg::CH_R) > (t & pfe_pkg::CH_R)) return c - pfe_pkg::ST_R;
        if ((c & pfe_pkg::CH_G) < (t & pfe_pkg::CH_G)) return c + pfe_pkg::ST_G;
        if ((c & pfe_pkg::CH_G) > (t & pfe_pkg::CH_G)) return c - pfe_pkg::ST_G;
        if ((c & pfe_pkg::CH_B) < (t & pfe_pkg::CH_B)) return c + pfe_pkg::ST_B;
        if ((c & pfe_pkg::CH_B) > (t & pfe_pkg::CH_B)) return c - pfe_pkg::ST_B;
        return c;
      end
      pfe_pkg::FM_FROM_WHITE: begin
        if (c == t) return c;
        if (c >= pfe_pkg::ST_B) begin
          d = c - pfe_pkg::ST_B;
          if (d >= t) return d;
        end
        if (c >= pfe_pkg::ST_G) begin
          d = c - pfe_pkg::ST_G;
          if (d >= t) return d;
        end
        // Red goes down regardless, wrapping below zero.
        return c - pfe_pkg::ST_R;
      end
      default: begin
        if (c == pfe_pkg::WHITE_WORD) return c;
        if ((c & pfe_pkg::CH_R) != pfe_pkg::CH_R) return c + pfe_pkg::ST_R;
        if ((c & pfe_pkg::CH_G) != pfe_pkg::CH_G) return c + pfe_pkg::ST_G;
        if ((c & pfe_pkg::CH_B) != pfe_pkg::CH_B) return c + pfe_pkg::ST_B;
        return c;
      end
    endcase
  endfunction

  // Applies one request to the predicted palettes and queues its response words.
  function automatic void palette_apply(pfe_pkg::req_t r);
    pfe_pkg::rsp_t w;
    int   e;
    int   e_end;
    if (r.func != pfe_pkg::FN_FADE) begin
      w.out_index = r.entry_index;
      w.out_color = '0;
      w.last      = 1'b1;
      // Entries beyond the palette are left alone and read as zero.
      if (pfe_pkg::idx_ok(r.entry_index)) begin
        if (r.func == pfe_pkg::FN_WR_ACT) act_pal[r.entry_index] = r.color_word;
        else if (r.func == pfe_pkg::FN_WR_TGT) tgt_pal[r.entry_index] = r.color_word;
        w.out_color = act_pal[r.entry_index];
      end
      awaited_words.push_back(w);
    end else begin
      // Entries past the end of the palette are skipped.
      e_end = int'(cur_first) + int'(cur_span);
      if (e_end > pfe_pkg::FADE_LIMIT) e_end = pfe_pkg::FADE_LIMIT;
      for (e = int'(cur_first); e <= e_end; e++) begin
        act_pal[e] = faded_colour(cur_mode, act_pal[e], tgt_pal[e]);
        w.out_index = pfe_pkg::idx_t'(e);
        w.out_color = act_pal[e];
        w.last      = (e == e_end);
        awaited_words.push_back(w);
      end
    end
  endfunction

  function automatic int unsigned draw_wait(logic calm);
    return calm ? 0 : $urandom_range(0, 11);
  endfunction

  // Request driver: presents backlog words, with a random gap after each one unless calm.
  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && req_ready) begin
        palette_apply(req);
        n_taken++;
        tx_wait = draw_wait(tx_calm);
      end
      if (!req_valid || req_ready) begin
        if (tx_wait != 0) begin
          tx_wait--;
          req_valid <= 1'b0;
        end else if (req_backlog.size() != 0) begin
          req       <= req_backlog.pop_front();
          req_valid <= 1'b1;
        end else begin
          req_valid <= 1'b0;
        end
      end
    end
  end

  // Long hold-off of the response side, counted down on its own.
  always @(posedge clk) begin
    if (hold_arm) hold_left <= HOLD_CYCLES;
    else if (hold_left != 0) hold_left <= hold_left - 1;
  end

  // Response monitor: checks each word against the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ready <= 1'b0;
    end else begin
      if (rsp_valid && rsp_ready) begin
        if (awaited_words.size() == 0) begin
          n_bad++;
          if (n_bad <= 10)
            $display("unexpected word: index %0d colour %h last %b",
                     rsp.out_index, rsp.out_color, rsp.last);
        end else begin
          want_w = awaited_words.pop_front();
          if (rsp.out_index !== want_w.out_index || rsp.out_color !== want_w.out_color ||
              rsp.last !== want_w.last) begin
            n_bad++;
            if (n_bad <= 10)
              $display("mismatch: want index %0d colour %h last %b, got %0d %h %b",
                       want_w.out_index, want_w.out_color, want_w.last,
                       rsp.out_index, rsp.out_color, rsp.last);
          end
        end
        rx_wait = draw_wait(rx_calm);
      end
      if (hold_left != 0) begin
        rsp_ready <= 1'b0;
      end else if (rx_wait != 0) begin
        rx_wait--;
        rsp_ready <= 1'b0;
      end else begin
        rsp_ready <= 1'b1;
      end
    end
  end

  // Writes one fade register and mirrors it into the predictor.
  task automatic set_reg(pfe_pkg::cfg_reg_e r, logic [pfe_pkg::CFG_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_index <= r;
    cfg_data  <= v;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (r)
      pfe_pkg::CFG_MODE:  cur_mode  = pfe_pkg::fade_mode_e'(v[1:0]);
      pfe_pkg::CFG_FIRST: cur_first = pfe_pkg::idx_t'(v);
      default:            cur_span  = pfe_pkg::idx_t'(v);
    endcase
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_fade(pfe_pkg::fade_mode_e m, pfe_pkg::idx_t f, pfe_pkg::idx_t s);
    set_reg(pfe_pkg::CFG_MODE, pfe_pkg::CFG_W'(m));
    set_reg(pfe_pkg::CFG_FIRST, f);
    set_reg(pfe_pkg::CFG_SPAN, s);
  endtask

  task automatic send(pfe_pkg::func_e f, pfe_pkg::idx_t i, pfe_pkg::color_t c);
    pfe_pkg::req_t r;
    r.func        = f;
    r.entry_index = i;
    r.color_word  = c;
    req_backlog.push_back(r);
    n_queued++;
  endtask

  // Waits until every request is taken and every response word has arrived.
  task automatic drain;
    while (n_taken != n_queued || awaited_words.size() != 0) @(posedge clk);
  endtask

  initial begin
    #10_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    int                  ph;
    int                  j;
    int                  k;
    pfe_pkg::func_e      f;
    pfe_pkg::idx_t       idx;
    pfe_pkg::idx_t       first;
    pfe_pkg::idx_t       span;
    pfe_pkg::color_t     colour;
    pfe_pkg::fade_mode_e mode;

    repeat (12) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: reads of cleared entries, extreme words, full black fade.
    send(pfe_pkg::FN_RD_ACT, 6'd0, 16'h0000);
    send(pfe_pkg::FN_RD_ACT, 6'd63, 16'h0000);
    send(pfe_pkg::FN_WR_ACT, 6'd0, 16'hFFFF);
    send(pfe_pkg::FN_WR_ACT, 6'd63, 16'h0000);
    send(pfe_pkg::FN_WR_TGT, 6'd63, 16'hFFFF);
    send(pfe_pkg::FN_WR_TGT, 6'd0, 16'h0000);
    send(pfe_pkg::FN_WR_ACT, 6'd1, 16'h0EEE);
    send(pfe_pkg::FN_WR_ACT, 6'd2, 16'h0E00);
    send(pfe_pkg::FN_WR_ACT, 6'd3, 16'h00E0);
    send(pfe_pkg::FN_RD_ACT, 6'd0, 16'hFFFF);
    send(pfe_pkg::FN_FADE, 6'd0, 16'h0000);
    drain;

    // Toward target near the palette end, with an entry already at its target.
    set_fade(pfe_pkg::FM_TARGET, 6'd60, 6'd63);
    send(pfe_pkg::FN_WR_TGT, 6'd61, 16'h0246);
    send(pfe_pkg::FN_WR_ACT, 6'd61, 16'h0EEE);
    send(pfe_pkg::FN_WR_ACT, 6'd62, 16'h0AAA);
    send(pfe_pkg::FN_WR_TGT, 6'd62, 16'h0AAA);
    send(pfe_pkg::FN_FADE, 6'd63, 16'hFFFF);
    drain;

    // From white, including red wrapping below zero.
    set_fade(pfe_pkg::FM_FROM_WHITE, 6'd10, 6'd2);
    send(pfe_pkg::FN_WR_ACT, 6'd10, 16'h0000);
    send(pfe_pkg::FN_WR_TGT, 6'd10, 16'h0004);
    send(pfe_pkg::FN_WR_ACT, 6'd11, 16'h0EEE);
    send(pfe_pkg::FN_WR_TGT, 6'd11, 16'h0222);
    send(pfe_pkg::FN_FADE, 6'd0, 16'h0000);
    send(pfe_pkg::FN_FADE, 6'd0, 16'h0000);
    drain;

    // To white on the last entry alone, then once more when already white.
    set_fade(pfe_pkg::FM_WHITE, 6'd63, 6'd0);
    send(pfe_pkg::FN_FADE, 6'd0, 16'h0000);
    send(pfe_pkg::FN_WR_ACT, 6'd63, 16'h0EEE);
    send(pfe_pkg::FN_FADE, 6'd0, 16'h0000);
    drain;

    // Random phases: load the fade window, then mix fades with accesses.
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      tx_calm = (ph % 4 == 1);
      rx_calm = (ph % 4 == 1) || (ph % 4 == 3);
      mode    = pfe_pkg::fade_mode_e'(ph % 4);
      case ($urandom_range(0, 3))
        0:       first = '0;
        1:       first = pfe_pkg::idx_t'(63);
        default: first = pfe_pkg::idx_t'($urandom);
      endcase
      case ($urandom_range(0, 5))
        0:       span = '0;
        1:       span = pfe_pkg::idx_t'(63);
        default: span = pfe_pkg::idx_t'($urandom_range(0, 7));
      endcase
      set_fade(mode, first, span);

      for (j = 0; j < PHASE_ITEMS; j++) begin
        k = $urandom_range(0, 99);
        if (j < 10)
          f = (k < 50) ? pfe_pkg::FN_WR_ACT : (k < 90) ? pfe_pkg::FN_WR_TGT :
              pfe_pkg::FN_RD_ACT;
        else
          f = (k < 20) ? pfe_pkg::FN_WR_ACT : (k < 35) ? pfe_pkg::FN_WR_TGT :
              (k < 55) ? pfe_pkg::FN_RD_ACT : pfe_pkg::FN_FADE;
        if ($urandom_range(0, 9) < 7) idx = pfe_pkg::idx_t'(first + $urandom_range(0, span));
        else idx = pfe_pkg::idx_t'($urandom);
        // Mostly clean 0BGR words, sometimes arbitrary bits.
        if ($urandom_range(0, 3) != 0)
          colour = pfe_pkg::color_t'($urandom) & pfe_pkg::WHITE_WORD;
        else
          colour = pfe_pkg::color_t'($urandom);
        send(f, idx, colour);
      end

      // Hold the response side off while requests keep coming.
      if (ph == 2) begin
        hold_arm <= 1'b1;
        @(posedge clk);
        hold_arm <= 1'b0;
      end
      drain;
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    n_bad += awaited_words.size();
    if (n_bad == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

endmodule
